// File: rtl/mdip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discrete input poller package
// Shared types, codes, widths and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mdip_pkg;

	localparam int unsigned REPLY_BYTES  = 7;
	localparam int unsigned REQ_BYTES    = 8;
	localparam int unsigned CNT_W        = 3;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned HOLD_DEPTH   = 3;

	localparam logic [7:0]  FUNC_READ_DI = 8'd2;
	localparam logic [7:0]  READ_COUNT   = 8'd16;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [15:0] TICK_MAX     = 16'hFFFF;

	localparam logic [CNT_W-1:0] CRC_STOP   = CNT_W'(REPLY_BYTES - 2);
	localparam logic [CNT_W-1:0] REPLY_LAST = CNT_W'(REPLY_BYTES - 1);
	localparam logic [CNT_W-1:0] HOLD_FIRST = 3'd3;
	localparam logic [CNT_W-1:0] HOLD_END   = 3'd5;
	localparam logic [CNT_W-1:0] REQ_CRC_LO = 3'd6;
	localparam logic [CNT_W-1:0] REQ_CRC_HI = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd1;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_POLL = 2'd1,
		CMD_BYTE = 2'd2,
		CMD_FAIL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_REPLY = 2'd1,
		ST_CRC_BAD  = 2'd2,
		ST_TOO_SOON = 2'd3
	} status_t;

	typedef enum logic {
		KIND_TX      = 1'b0,
		KIND_OUTCOME = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tx_data;
		logic        last;
		logic [15:0] input_bits;
		status_t     status;
	} res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Fixed request bytes after the address; CRC bytes are handled apart.
	function automatic logic [7:0] req_const(input logic [CNT_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			3'd1:    b = FUNC_READ_DI;
			3'd5:    b = READ_COUNT;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/mdip_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discrete input poller channels
// Command item channel, result item channel and register write channel.
// ----------------------------------------------------------------------------
interface mdip_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] rx_data;
	modport source (output valid, cmd, rx_data, input ready);
	modport sink   (input valid, cmd, rx_data, output ready);
endinterface

interface mdip_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_data;
	logic        last;
	logic [15:0] input_bits;
	logic [1:0]  status;
	modport source (output valid, kind, tx_data, last, input_bits, status, input ready);
	modport sink   (input valid, kind, tx_data, last, input_bits, status, output ready);
endinterface

interface mdip_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/modbus_discrete_input_poller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus discrete input poller
// Modbus RTU master that reads sixteen discrete inputs (function 2) from
// one station, paced by tick items, and reports the input bits or a fault.
// ----------------------------------------------------------------------------
//
//  Channel   Role    Payload                                    Moves
//  --------  ------  -----------------------------------------  ----------------
//  items     sink    cmd, rx_data                               tick/poll/byte/fail
//  results   source  kind, tx_data, last, input_bits, status    request byte/outcome
//  cfg       sink    index, data                                register write
//
// A tick, a reply byte or a failure item is taken in a single handshake; items
// that give no result are taken in every cycle the result buffer has room. A
// poll that goes ahead produces eight request bytes, one per cycle unless the
// buffer is full; the command channel holds ready low after the poll item
// while the request sequencer walks the remaining bytes with its running CRC.
// Results pass through an output register with one skid entry, so a stalled
// result consumer costs at most one further accepted item before ready drops.
// Reset clears the counters, the pending-reply flag and the registers to
// station address 1 and a minimum interval of zero; no clearing pass is needed.
//
// Behavior notes:
//   The elapsed tick counter saturates at its top value and restarts only
//   after a reply whose CRC matches.
//   A poll always drops any reply still pending, without an outcome.
//   Reply bytes and failure items that arrive with no reply pending are
//   taken and produce nothing.
//   The reply CRC covers the first five reply bytes; the address and
//   function bytes are not checked otherwise.
// ----------------------------------------------------------------------------
module modbus_discrete_input_poller import mdip_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mdip_item_if.sink     items,
	mdip_result_if.source results,
	mdip_cfg_if.sink      cfg
);

	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_data;

	// Command decode, request sequencing and reply checking.
	mdip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Result register with skid entry toward the result consumer.
	mdip_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (res_valid),
		.up_ready   (res_ready),
		.up_data    (res),
		.down_valid (results.valid),
		.down_ready (results.ready),
		.down_data  (out_data)
	);

	assign results.kind       = out_data.kind;
	assign results.tx_data    = out_data.tx_data;
	assign results.last       = out_data.last;
	assign results.input_bits = out_data.input_bits;
	assign results.status     = out_data.status;

endmodule

// File: rtl/mdip_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discrete input poller result buffer
// Output register with one skid entry, so upstream ready never depends on
// the downstream ready of the same cycle.
// ----------------------------------------------------------------------------
module mdip_skid import mdip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  res_t up_data,
	output logic down_valid,
	input  logic down_ready,
	output res_t down_data
);

	logic out_valid_q;
	res_t out_data_q;
	logic skid_valid_q;
	res_t skid_data_q;

	assign up_ready   = !skid_valid_q;
	assign down_valid = out_valid_q;
	assign down_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || down_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= up_valid;
			end
		end else if (up_valid && up_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || down_ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : up_data;
		end else if (up_valid && up_ready) begin
			skid_data_q <= up_data;
		end
	end

endmodule

// File: rtl/mdip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discrete input poller control
// Tick counter, request sequencer with running CRC, reply collection and
// reply CRC check.
// ----------------------------------------------------------------------------
module mdip_ctrl import mdip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mdip_item_if.sink   items,
	mdip_cfg_if.sink    cfg,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	logic [7:0]       slave_addr_q;
	logic [15:0]      min_interval_q;
	logic [15:0]      elapsed_q;
	logic             awaiting_q;
	logic [CNT_W-1:0] rcount_q;
	logic [15:0]      rcrc_q;
	logic [7:0]       hold_q [HOLD_DEPTH];
	logic             tx_active_q;
	logic [CNT_W-1:0] tx_idx_q;
	logic [15:0]      tx_crc_q;

	logic        item_ready;
	logic        acc;
	cmd_t        cmd;
	logic        too_soon;
	logic [1:0]  hold_idx;
	logic [7:0]  tx_byte;
	logic        reply_done;
	logic        reply_crc_ok;

	assign item_ready  = !tx_active_q && res_ready;
	assign items.ready = item_ready;
	assign acc         = items.valid && item_ready;
	assign cmd         = cmd_t'(items.cmd);
	assign too_soon    = elapsed_q < min_interval_q;
	assign hold_idx    = rcount_q[1:0] - 2'd3;
	assign reply_done  = awaiting_q && (rcount_q == REPLY_LAST);
	assign reply_crc_ok = ({items.rx_data, hold_q[2]} == rcrc_q);
	assign cfg.ready   = 1'b1;

	always_comb begin
		case (tx_idx_q)
			REQ_CRC_LO: tx_byte = tx_crc_q[7:0];
			REQ_CRC_HI: tx_byte = tx_crc_q[15:8];
			default:    tx_byte = req_const(tx_idx_q);
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (tx_active_q) begin
			res_valid   = res_ready;
			res.kind    = KIND_TX;
			res.tx_data = tx_byte;
			res.last    = (tx_idx_q == REQ_CRC_HI);
		end else if (acc) begin
			case (cmd)
				CMD_POLL: begin
					res_valid = 1'b1;
					if (too_soon) begin
						res.kind   = KIND_OUTCOME;
						res.last   = 1'b1;
						res.status = ST_TOO_SOON;
					end else begin
						res.kind    = KIND_TX;
						res.tx_data = slave_addr_q;
					end
				end
				CMD_FAIL: begin
					res_valid  = awaiting_q;
					res.kind   = KIND_OUTCOME;
					res.last   = 1'b1;
					res.status = ST_NO_REPLY;
				end
				CMD_BYTE: begin
					res_valid = reply_done;
					res.kind  = KIND_OUTCOME;
					res.last  = 1'b1;
					if (reply_crc_ok) begin
						res.input_bits = {hold_q[1], hold_q[0]};
						res.status     = ST_OK;
					end else begin
						res.status = ST_CRC_BAD;
					end
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q   <= 8'd1;
			min_interval_q <= 16'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SLAVE_ADDR:   slave_addr_q   <= cfg.data[7:0];
				REG_MIN_INTERVAL: min_interval_q <= cfg.data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			awaiting_q  <= 1'b0;
			rcount_q    <= '0;
			rcrc_q      <= CRC_INIT;
			tx_active_q <= 1'b0;
			tx_idx_q    <= '0;
			tx_crc_q    <= CRC_INIT;
		end else if (tx_active_q) begin
			if (res_ready) begin
				tx_idx_q <= tx_idx_q + 3'd1;
				if (tx_idx_q < REQ_CRC_LO) begin
					tx_crc_q <= crc_byte(tx_crc_q, tx_byte);
				end
				if (tx_idx_q == REQ_CRC_HI) begin
					tx_active_q <= 1'b0;
				end
			end
		end else if (acc) begin
			case (cmd)
				CMD_TICK: begin
					if (elapsed_q != TICK_MAX) begin
						elapsed_q <= elapsed_q + 16'd1;
					end
				end
				CMD_POLL: begin
					awaiting_q <= 1'b0;
					if (!too_soon) begin
						awaiting_q  <= 1'b1;
						rcount_q    <= '0;
						rcrc_q      <= CRC_INIT;
						tx_active_q <= 1'b1;
						tx_idx_q    <= 3'd1;
						tx_crc_q    <= crc_byte(CRC_INIT, slave_addr_q);
					end
				end
				CMD_FAIL: begin
					awaiting_q <= 1'b0;
				end
				CMD_BYTE: begin
					if (awaiting_q) begin
						if (rcount_q < CRC_STOP) begin
							rcrc_q <= crc_byte(rcrc_q, items.rx_data);
						end
						if (reply_done) begin
							awaiting_q <= 1'b0;
							rcount_q   <= '0;
							if (reply_crc_ok) begin
								elapsed_q <= '0;
							end
						end else begin
							rcount_q <= rcount_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Reply byte store: bytes three to five of the reply.
	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_BYTE && awaiting_q &&
		    rcount_q >= HOLD_FIRST && rcount_q <= HOLD_END) begin
			hold_q[hold_idx] <= items.rx_data;
		end
	end

	// While a request burst runs, a reply is always pending.
	a_burst_awaits: assert property (@(posedge clk) disable iff (!arst_n)
		tx_active_q |-> awaiting_q)
		else $error("request burst without pending reply");

	// No command is taken while request bytes are still going out.
	a_no_take_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		tx_active_q |-> !items.ready)
		else $error("command taken during request burst");

	// An accepted poll that is not too soon starts a burst at byte one.
	a_poll_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd == CMD_POLL && !too_soon) |=> (tx_active_q && tx_idx_q == 3'd1))
		else $error("poll did not start request burst");

	// The reply counter never runs past the last reply byte.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rcount_q <= REPLY_LAST)
		else $error("reply counter out of range");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discrete input poller testbench
// Drives tick, poll, reply byte and failure items into the poller. A shadow
// of its state predicts every request byte and read outcome, and each result
// item is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top import mdip_pkg::*; ();

	// Cycles to let pass after the last expected result before the poller
	// counts as idle: eight request bytes plus the output register and skid.
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned PHASE_ITEMS  = 80;

	// Shadow of the poller: it tracks the registers, the tick counter and the
	// reply in progress, and queues the result items that each command causes.
	class poll_tracker;
		logic [7:0]  station;
		logic [15:0] min_ticks;
		logic [15:0] ticks_since_read;
		bit          reply_open;
		int unsigned reply_pos;
		logic [15:0] reply_crc;
		logic [7:0]  reply_keep [3];
		res_t        pending_out [$];
		int unsigned faults;
		int unsigned tx_seen, ok_seen, crc_seen, lost_seen, early_seen;

		function new();
			station          = 8'd1;
			min_ticks        = 16'd0;
			ticks_since_read = 16'd0;
			reply_open       = 1'b0;
			reply_pos        = 0;
			reply_crc        = CRC_INIT;
			faults           = 0;
			tx_seen          = 0;
			ok_seen          = 0;
			crc_seen         = 0;
			lost_seen        = 0;
			early_seen       = 0;
		endfunction

		// Bit-serial form of the CRC-16/MODBUS update, one data bit per step.
		static function logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
			logic [15:0] r;
			logic        fb;
			r = crc;
			for (int k = 0; k < 8; k++) begin
				fb = r[0] ^ b[k];
				r  = r >> 1;
				if (fb) begin
					r = r ^ CRC_POLY;
				end
			end
			return r;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [15:0] val);
			case (idx)
				REG_SLAVE_ADDR:   station = val[7:0];
				REG_MIN_INTERVAL: min_ticks = val;
				default: ;
			endcase
		endfunction

		function void push_out(input kind_t k, input logic [7:0] tx, input logic lst,
				input logic [15:0] bits, input status_t st);
			res_t r;
			r.kind       = k;
			r.tx_data    = tx;
			r.last       = lst;
			r.input_bits = bits;
			r.status     = st;
			pending_out.push_back(r);
		endfunction

		// Returns 1 when the item did something, 0 when the poller ignores it.
		function bit note_command(input cmd_t cmd, input logic [7:0] rx);
			logic [7:0]  req [8];
			logic [15:0] crc;
			logic [15:0] got;
			if (cmd == CMD_TICK) begin
				if (ticks_since_read != TICK_MAX) begin
					ticks_since_read = ticks_since_read + 16'd1;
				end
				return 1'b1;
			end
			if (cmd == CMD_POLL) begin
				reply_open = 1'b0;
				if (ticks_since_read < min_ticks) begin
					push_out(KIND_OUTCOME, 8'h00, 1'b1, 16'h0000, ST_TOO_SOON);
					return 1'b1;
				end
				req[0] = station;
				req[1] = FUNC_READ_DI;
				req[2] = 8'h00;
				req[3] = 8'h00;
				req[4] = 8'h00;
				req[5] = READ_COUNT;
				crc = CRC_INIT;
				for (int i = 0; i < 6; i++) begin
					crc = crc_next(crc, req[i]);
				end
				req[6] = crc[7:0];
				req[7] = crc[15:8];
				for (int i = 0; i < 8; i++) begin
					push_out(KIND_TX, req[i], (i == 7), 16'h0000, ST_OK);
				end
				reply_open = 1'b1;
				reply_pos  = 0;
				reply_crc  = CRC_INIT;
				return 1'b1;
			end
			if (!reply_open) begin
				return 1'b0;
			end
			if (cmd == CMD_FAIL) begin
				reply_open = 1'b0;
				push_out(KIND_OUTCOME, 8'h00, 1'b1, 16'h0000, ST_NO_REPLY);
				return 1'b1;
			end
			// A reply byte: the CRC runs over all but the two CRC bytes, and the
			// two data bytes plus the low CRC byte are kept for the final check.
			if (reply_pos < REPLY_BYTES - 2) begin
				reply_crc = crc_next(reply_crc, rx);
			end
			if (reply_pos >= 3 && reply_pos <= 5) begin
				reply_keep[reply_pos - 3] = rx;
			end
			if (reply_pos < REPLY_BYTES - 1) begin
				reply_pos++;
				return 1'b1;
			end
			reply_open = 1'b0;
			reply_pos  = 0;
			got = {rx, reply_keep[2]};
			if (got != reply_crc) begin
				push_out(KIND_OUTCOME, 8'h00, 1'b1, 16'h0000, ST_CRC_BAD);
			end else begin
				ticks_since_read = 16'd0;
				push_out(KIND_OUTCOME, 8'h00, 1'b1, {reply_keep[1], reply_keep[0]}, ST_OK);
			end
			return 1'b1;
		endfunction

		function void field_ok(input string what, input logic [15:0] want,
				input logic [15:0] got);
			if (got !== want) begin
				faults++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			end
		endfunction

		function void check_output(input res_t got);
			res_t want;
			if (pending_out.size() == 0) begin
				faults++;
				$display("%0t: result item with none expected, expected nothing, actual %0h",
					$time, got);
				return;
			end
			want = pending_out.pop_front();
			field_ok("kind", 16'(want.kind), 16'(got.kind));
			field_ok("tx_data", 16'(want.tx_data), 16'(got.tx_data));
			field_ok("last", 16'(want.last), 16'(got.last));
			field_ok("input_bits", want.input_bits, got.input_bits);
			field_ok("status", 16'(want.status), 16'(got.status));
			if (want.kind == KIND_TX) begin
				tx_seen++;
			end else begin
				case (want.status)
					ST_OK:       ok_seen++;
					ST_CRC_BAD:  crc_seen++;
					ST_NO_REPLY: lost_seen++;
					default:     early_seen++;
				endcase
			end
		endfunction

		function int unsigned pending();
			return pending_out.size();
		endfunction
	endclass

	typedef enum int {
		RP_GOOD,
		RP_CORRUPT,
		RP_SHORT,
		RP_CUT,
		RP_EXTRA
	} reply_mode_t;

	logic clk;
	logic arst_n;

	mdip_item_if   item_ch();
	mdip_result_if res_ch();
	mdip_cfg_if    cfg_ch();

	modbus_discrete_input_poller uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	poll_tracker sb;

	// Sender gap chance in percent, and a flag that turns all idling off for
	// the closing part of the run.
	int unsigned gap_pct;
	bit          calm;
	int unsigned items_used;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	// Result consumer. Ready alternates between runs of acceptance and stalls;
	// in the calm part it stays high throughout.
	initial begin
		int unsigned left;
		bit          level;
		res_ch.ready = 1'b0;
		left  = 0;
		level = 1'b1;
		forever begin
			@(negedge clk);
			if (calm) begin
				level = 1'b1;
			end else if (left == 0) begin
				level = !level;
				left  = level ? $urandom_range(0, 40) : $urandom_range(0, 11);
			end else begin
				left--;
			end
			res_ch.ready <= level;
		end
	end

	// Result monitor: every accepted result item goes to the shadow for checking.
	always @(posedge clk) begin
		res_t seen;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen.kind       = kind_t'(res_ch.kind);
			seen.tx_data    = res_ch.tx_data;
			seen.last       = res_ch.last;
			seen.input_bits = res_ch.input_bits;
			seen.status     = status_t'(res_ch.status);
			sb.check_output(seen);
		end
	end

	// Offers one command item. Valid stays high from one item to the next
	// unless a random gap drops it first; the shadow learns of the item at
	// the edge where it is accepted.
	task automatic send_item(input cmd_t c, input logic [7:0] d);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 11)) @(negedge clk);
		end
		@(negedge clk);
		item_ch.valid   <= 1'b1;
		item_ch.cmd     <= c;
		item_ch.rx_data <= d;
		do @(posedge clk); while (!item_ch.ready);
		if (sb.note_command(c, d)) begin
			items_used++;
		end
	endtask

	// Waits until every predicted result has arrived, then lets the poller
	// finish any item that causes no result before it is treated as idle.
	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only while the poller is idle.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Plays one station reply. The header bytes are partly random, since only
	// the CRC decides the outcome. A corrupted reply has one bit flipped in
	// any of its seven bytes, which the CRC always catches. A short reply
	// ends in a failure item; a cut reply just stops, leaving the read open
	// for the next poll to drop. Ticks may fall between reply bytes.
	task automatic send_reply(input reply_mode_t mode, input logic [15:0] bits);
		logic [7:0]  b [7];
		logic [15:0] crc;
		int unsigned upto;
		b[0] = $urandom_range(0, 1) ? sb.station : 8'($urandom);
		b[1] = $urandom_range(0, 1) ? FUNC_READ_DI : 8'($urandom);
		b[2] = $urandom_range(0, 3) != 0 ? 8'd2 : 8'($urandom);
		b[3] = bits[7:0];
		b[4] = bits[15:8];
		crc = CRC_INIT;
		for (int i = 0; i < 5; i++) begin
			crc = sb.crc_next(crc, b[i]);
		end
		b[5] = crc[7:0];
		b[6] = crc[15:8];
		if (mode == RP_CORRUPT) begin
			b[$urandom_range(0, 6)] ^= 8'(1 << $urandom_range(0, 7));
		end
		upto = (mode == RP_SHORT || mode == RP_CUT) ? $urandom_range(0, 6) : 7;
		for (int i = 0; i < upto; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				send_item(CMD_TICK, 8'($urandom));
			end
			send_item(CMD_BYTE, b[i]);
		end
		if (mode == RP_SHORT) begin
			send_item(CMD_FAIL, 8'($urandom));
		end else if (mode == RP_EXTRA) begin
			// Stray traffic after the read has closed is ignored.
			send_item($urandom_range(0, 1) ? CMD_BYTE : CMD_FAIL, 8'($urandom));
		end
	endtask

	// One random piece of traffic: mostly a poll after a few ticks followed by
	// a reply of some shape, and now and then noise or a bare run of ticks.
	task automatic random_sequence(input int unsigned tick_span);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom));
		end else if (pick < 20) begin
			repeat ($urandom_range(1, 4)) send_item(CMD_TICK, 8'($urandom));
		end else begin
			repeat ($urandom_range(0, tick_span)) send_item(CMD_TICK, 8'($urandom));
			send_item(CMD_POLL, 8'($urandom));
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_reply(RP_GOOD, 16'($urandom));
			end else if (pick < 70) begin
				send_reply(RP_CORRUPT, 16'($urandom));
			end else if (pick < 82) begin
				send_reply(RP_SHORT, 16'($urandom));
			end else if (pick < 92) begin
				send_reply(RP_CUT, 16'($urandom));
			end else begin
				send_reply(RP_EXTRA, 16'($urandom));
			end
		end
		// Occasionally hold the sender back until the poller has drained.
		if ($urandom_range(0, 99) < 4) begin
			settle();
		end
	endtask

	initial begin
		int unsigned span;
		int unsigned goal;
		sb = new();
		item_ch.valid   = 1'b0;
		item_ch.cmd     = CMD_TICK;
		item_ch.rx_data = 8'h00;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = REG_SLAVE_ADDR;
		cfg_ch.data     = 16'h0000;
		calm       = 1'b0;
		gap_pct    = 20;
		items_used = 0;
		arst_n     = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, reset registers: station 1, no minimum interval.
		// Bytes and failures with no read pending are ignored.
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_FAIL, 8'h00);
		// A good read with every input set, then a CRC mismatch, then a short
		// reply that ends in a failure.
		send_item(CMD_POLL, 8'h00);
		send_reply(RP_GOOD, 16'hFFFF);
		send_item(CMD_POLL, 8'hFF);
		send_reply(RP_CORRUPT, 16'h1234);
		send_item(CMD_POLL, 8'h00);
		send_item(CMD_BYTE, 8'h01);
		send_item(CMD_BYTE, 8'h02);
		send_item(CMD_FAIL, 8'hFF);
		// A poll in the middle of a reply drops the read and starts over.
		send_item(CMD_POLL, 8'h00);
		send_item(CMD_BYTE, 8'h01);
		send_item(CMD_POLL, 8'h00);
		send_reply(RP_GOOD, 16'h0000);
		settle();

		// Station 0 and a minimum of three ticks: the first poll is too
		// soon, the one after three ticks goes ahead.
		write_reg(REG_SLAVE_ADDR, 16'h0000);
		write_reg(REG_MIN_INTERVAL, 16'd3);
		send_item(CMD_POLL, 8'h00);
		repeat (3) send_item(CMD_TICK, 8'h00);
		send_item(CMD_POLL, 8'h00);
		send_item(CMD_FAIL, 8'h00);
		settle();

		// Station 255 and the largest interval: every poll here is too soon,
		// and the failure after it finds no read pending.
		write_reg(REG_SLAVE_ADDR, 16'h00FF);
		write_reg(REG_MIN_INTERVAL, 16'hFFFF);
		send_item(CMD_POLL, 8'h00);
		repeat (3) send_item(CMD_TICK, 8'($urandom));
		send_item(CMD_POLL, 8'h00);
		send_item(CMD_FAIL, 8'h00);
		settle();

		// Random part in phases with different register settings. The ticks
		// before a poll are scaled to the interval so that both too-soon and
		// accepted polls occur. Phase 0 runs without sender gaps, and the
		// last phase runs with no idling on either side.
		for (int phase = 0; phase < 5; phase++) begin
			settle();
			case (phase)
				0: begin
					write_reg(REG_SLAVE_ADDR, 16'($urandom_range(0, 255)));
					write_reg(REG_MIN_INTERVAL, 16'd0);
					span    = 2;
					gap_pct = 0;
				end
				1: begin
					write_reg(REG_SLAVE_ADDR, 16'h0000);
					write_reg(REG_MIN_INTERVAL, 16'($urandom_range(1, 4)));
					span    = sb.min_ticks + 2;
					gap_pct = 15;
				end
				2: begin
					write_reg(REG_SLAVE_ADDR, 16'h00FF);
					write_reg(REG_MIN_INTERVAL, 16'($urandom_range(2, 10)));
					span    = sb.min_ticks + 2;
					gap_pct = 25;
				end
				3: begin
					write_reg(REG_SLAVE_ADDR, 16'($urandom_range(0, 255)));
					write_reg(REG_MIN_INTERVAL, 16'($urandom));
					span    = 3;
					gap_pct = 20;
				end
				default: begin
					write_reg(REG_SLAVE_ADDR, 16'($urandom_range(0, 255)));
					write_reg(REG_MIN_INTERVAL, 16'($urandom_range(0, 3)));
					span    = sb.min_ticks + 2;
					gap_pct = 0;
					calm    = 1'b1;
				end
			endcase
			goal = items_used + PHASE_ITEMS;
			while (items_used < goal) begin
				random_sequence(span);
			end
		end

		settle();
		$display("Covered %0d effective command items, %0d request bytes checked.",
			items_used, sb.tx_seen);
		$display("Read outcomes: %0d good, %0d CRC mismatch, %0d no reply, %0d too soon.",
			sb.ok_seen, sb.crc_seen, sb.lost_seen, sb.early_seen);
		if (sb.faults == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: modbus_discrete_input_poller.f
rtl/mdip_pkg.sv
rtl/mdip_if.sv
rtl/mdip_skid.sv
rtl/mdip_ctrl.sv
rtl/modbus_discrete_input_poller.sv
test/tb_top.sv
